/* hw/rtl/jtt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jtt_pkg
// Shared types, constants and status codes of the journal transaction tracker.
// ----------------------------------------------------------------------------
package jtt_pkg;

  localparam int LogSlots    = 32;
  localparam int MaxOpBlocks = 10;
  localparam int SlotW       = 5;
  localparam int UsedW       = 6;
  localparam int OpenW       = 3;
  localparam int CfgIdxW     = 1;
  localparam int QDepth      = 2;

  localparam logic [OpenW-1:0] OpenMax = 3'd7;

  typedef enum logic [1:0] {
    MODE_BEGIN  = 2'd0,
    MODE_WRITE  = 2'd1,
    MODE_END    = 2'd2,
    MODE_DONE   = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_GRANTED   = 4'd0,
    ST_WAIT      = 4'd1,
    ST_ABSORBED  = 4'd2,
    ST_APPENDED  = 4'd3,
    ST_ENDED     = 4'd4,
    ST_ENTRY     = 4'd5,
    ST_FINISHED  = 4'd6,
    ST_FULL      = 4'd7,
    ST_OUTSIDE   = 4'd8,
    ST_END_BUSY  = 4'd9,
    ST_NO_COMMIT = 4'd10
  } status_t;

  localparam logic [CfgIdxW-1:0] CFG_LOG_START = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_LOG_AREA  = 1'd1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] block_number;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [4:0]  slot;
    logic [31:0] home_block;
    logic [31:0] log_block;
    logic        last;
    logic [2:0]  open_count;
  } out_item_t;

  // Work handed from the front part to the back part.
  typedef struct packed {
    logic             dump;        // commit: emit count entries from the table
    logic [UsedW-1:0] count;
    out_item_t        item;        // single result when dump is low
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_READ  = 2'd1,
    BK_EMIT  = 2'd2
  } bk_state_t;

endpackage
`default_nettype wire

/* hw/rtl/jtt_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jtt_front
// Classifies each beat, updates the transaction counters and the slot table,
// and queues one job per beat for the back part.
// ----------------------------------------------------------------------------
module jtt_front
  import jtt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire in_item_t         in_item,
  input  wire logic [31:0]      log_start_block,
  input  wire logic [31:0]      log_area_blocks,
  output logic                  job_valid,
  output job_t                  job,
  input  wire logic             job_take,
  input  wire logic [SlotW-1:0] rd_addr,
  output logic [31:0]           rd_data
);

  logic [31:0]      table_mem [LogSlots];
  logic [UsedW-1:0] used_slots;
  logic [OpenW-1:0] open_ops;
  logic             commit_pending;
  logic             busy;           // dump in flight: table must not change
  logic             work;
  in_item_t         item_q;
  logic [LogSlots-1:0] hit_vec;
  logic [SlotW-1:0] hit_idx;
  logic             hit;
  job_t             job_q [QDepth];
  logic [1:0]       q_cnt;
  logic             q_rd;
  logic             q_full;
  job_t             res;
  logic [UsedW-1:0] used_next;
  logic [OpenW-1:0] open_next;
  logic             pend_next;
  logic             app;
  logic [31:0]      begin_need;

  // The item is registered first and then classified from that register.
  assign q_full = (q_cnt == 2'(QDepth));
  assign full   = work | q_full | busy;

  always_ff @(posedge clk) begin
    if (push && !full) item_q <= in_item;
    if (rst) work <= 1'b0;
    else     work <= push && !full;
  end

  always_comb begin
    hit_vec = '0;
    for (int i = 0; i < LogSlots; i++) begin
      hit_vec[i] = (i < int'(used_slots)) && (table_mem[i] == item_q.block_number);
    end
    hit_idx = '0;
    for (int i = LogSlots - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_idx = SlotW'(i);
    end
    hit = |hit_vec;
  end

  assign begin_need = 32'(used_slots) + 32'({1'b0, open_ops} + 4'd1) * 32'(MaxOpBlocks);

  always_comb begin
    res       = '0;
    res.item.last       = 1'b1;
    used_next = used_slots;
    open_next = open_ops;
    pend_next = commit_pending;
    app       = 1'b0;
    case (mode_t'(item_q.mode))
      MODE_BEGIN: begin
        if (commit_pending || open_ops >= OpenMax || begin_need > 32'(LogSlots)) begin
          res.item.status = ST_WAIT;
        end else begin
          open_next = open_ops + 3'd1;
          res.item.status = ST_GRANTED;
        end
      end
      MODE_WRITE: begin
        if (used_slots >= UsedW'(LogSlots) ||
            {27'd0, used_slots} + 33'd1 >= {1'b0, log_area_blocks}) begin
          res.item.status = ST_FULL;
        end else if (open_ops == '0) begin
          res.item.status = ST_OUTSIDE;
        end else if (hit) begin
          res.item.status     = ST_ABSORBED;
          res.item.slot       = hit_idx;
          res.item.home_block = item_q.block_number;
          res.item.log_block  = log_start_block + 32'(hit_idx) + 32'd1;
        end else begin
          app = 1'b1;
          used_next = used_slots + 6'd1;
          res.item.status     = ST_APPENDED;
          res.item.slot       = SlotW'(used_slots);
          res.item.home_block = item_q.block_number;
          res.item.log_block  = log_start_block + 32'(used_slots) + 32'd1;
        end
      end
      MODE_END: begin
        if (commit_pending) begin
          res.item.status = ST_END_BUSY;
        end else if (open_ops == '0) begin
          res.item.status = ST_OUTSIDE;
        end else begin
          open_next = open_ops - 3'd1;
          if (open_ops != 3'd1 || used_slots == '0) begin
            res.item.status = ST_ENDED;
          end else begin
            pend_next = 1'b1;
            used_next = '0;
            res.dump  = 1'b1;
            res.count = used_slots;
          end
        end
      end
      default: begin
        if (!commit_pending) begin
          res.item.status = ST_NO_COMMIT;
        end else begin
          pend_next = 1'b0;
          res.item.status = ST_FINISHED;
        end
      end
    endcase
    res.item.open_count = open_next;
  end

  always_ff @(posedge clk) begin
    if (work && app) table_mem[SlotW'(used_slots)] <= item_q.block_number;
    rd_data <= table_mem[rd_addr];
  end

  // Job queue: two entries, in order. A new job never meets a full queue,
  // since full holds the input off while both entries are taken.
  assign job_valid = (q_cnt != '0);
  assign job       = job_q[0];
  assign q_rd      = job_valid && job_take;

  always_ff @(posedge clk) begin
    if (q_rd) job_q[0] <= job_q[1];
    if (work) begin
      if (q_cnt == 2'd0 || (q_cnt == 2'd1 && q_rd)) job_q[0] <= res;
      else job_q[1] <= res;
    end
    if (rst) begin
      q_cnt          <= '0;
      used_slots     <= '0;
      open_ops       <= '0;
      commit_pending <= 1'b0;
      busy           <= 1'b0;
    end else begin
      q_cnt <= q_cnt + 2'(work) - 2'(q_rd);
      if (work) begin
        used_slots     <= used_next;
        open_ops       <= open_next;
        commit_pending <= pend_next;
      end
      if (work && res.dump)          busy <= 1'b1;
      else if (q_rd && job.dump)     busy <= 1'b0;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/jtt_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jtt_back
// Carries out queued jobs in order: single results pass through; a commit walks the
// slot table one entry at a time, stalling while the two-entry result queue is full.
// ----------------------------------------------------------------------------
module jtt_back
  import jtt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             job_valid,
  input  wire job_t             job,
  output logic                  job_take,
  output logic [SlotW-1:0]      rd_addr,
  input  wire logic [31:0]      rd_data,
  input  wire logic [31:0]      log_start_block,
  output logic                  empty,
  input  wire logic             pop,
  output out_item_t             out_item
);

  bk_state_t        state, state_next;
  logic [UsedW-1:0] idx;
  logic [UsedW-1:0] cnt;
  logic [OpenW-1:0] opn;
  out_item_t        oq [2];
  logic [1:0]       oc;
  logic             wr, rd;
  out_item_t        wdat;
  logic             room;

  assign empty    = (oc == '0);
  assign out_item = oq[0];
  assign rd       = !empty && pop;
  assign room     = (oc != 2'd2) || rd;
  assign rd_addr  = SlotW'(idx);

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (job_valid && job.dump) state_next = BK_READ;
      BK_READ: state_next = BK_EMIT;
      BK_EMIT: if (room) state_next = (idx + 6'd1 == cnt) ? BK_IDLE : BK_READ;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    job_take = 1'b0;
    wr       = 1'b0;
    wdat     = job.item;
    case (state)
      BK_IDLE: begin
        if (job_valid && !job.dump && room) begin
          job_take = 1'b1;
          wr       = 1'b1;
        end
      end
      BK_EMIT: begin
        wdat.status     = ST_ENTRY;
        wdat.slot       = SlotW'(idx);
        wdat.home_block = rd_data;
        wdat.log_block  = log_start_block + 32'(idx) + 32'd1;
        wdat.last       = (idx + 6'd1 == cnt);
        wdat.open_count = opn;
        wr              = room;
        job_take        = room && (idx + 6'd1 == cnt);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == BK_IDLE) begin
      idx <= '0;
      cnt <= job.count;
      opn <= job.item.open_count;
    end else if (state == BK_EMIT && room) begin
      idx <= idx + 6'd1;
    end
    if (rd) oq[0] <= oq[1];
    if (wr) begin
      if (oc == 2'd0 || (oc == 2'd1 && rd)) oq[0] <= wdat;
      else oq[1] <= wdat;
    end
    if (rst) begin
      state <= BK_IDLE;
      oc    <= '0;
    end else begin
      state <= state_next;
      oc    <= oc + 2'(wr) - 2'(rd);
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/journal_transaction_tracker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// journal_transaction_tracker
// Group-commit bookkeeping for a write-ahead journal.
// ----------------------------------------------------------------------------
// Each input beat (begin, write, end or commit done) is first registered and
// then classified against the 32-entry slot table, which is searched in
// parallel. The front part then queues a job and may take the next beat
// while the back part is still delivering. A single result passes from the
// input register through the job queue into the result queue when the result
// side is free. The final end of a transaction starts a commit, which emits
// the table entries one at a time from the table memory (a registered table
// read, then a hand-on of the entry) while the result side keeps up;
// further input beats are held off until the commit listing has been handed
// to the result queue. Configuration may only be written while idle.
// ----------------------------------------------------------------------------
module journal_transaction_tracker
  import jtt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire in_item_t           in_item,
  output logic                    empty,
  input  wire logic               pop,
  output out_item_t               out_item,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [31:0]        cfg_data
);

  logic [31:0]      log_start_block;
  logic [31:0]      log_area_blocks;
  logic             job_valid;
  job_t             job;
  logic             job_take;
  logic [SlotW-1:0] rd_addr;
  logic [31:0]      rd_data;

  // Configuration registers; user must write only while idle, unenforced.
  always_ff @(posedge clk) begin
    if (rst) begin
      log_start_block <= 32'd0;
      log_area_blocks <= 32'd33;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOG_START: log_start_block <= cfg_data;
        CFG_LOG_AREA:  log_area_blocks <= cfg_data;
        default: ;
      endcase
    end
  end

  jtt_front u_front (
    .clk, .rst, .push, .full, .in_item,
    .log_start_block, .log_area_blocks,
    .job_valid, .job, .job_take, .rd_addr, .rd_data
  );

  jtt_back u_back (
    .clk, .rst, .job_valid, .job, .job_take, .rd_addr, .rd_data,
    .log_start_block, .empty, .pop, .out_item
  );

endmodule
`default_nettype wire

/* hw/rtl/jtt_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jtt_checker
// Port-level checks of the journal transaction tracker.
// ----------------------------------------------------------------------------
module jtt_checker
  import jtt_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      push,
  input wire logic      full,
  input wire logic      empty,
  input wire logic      pop,
  input wire out_item_t out_item
);

  a_full_after_push: assert property (@(posedge clk) disable iff (rst)
    push && !full |=> full) else $error("accept not followed by busy");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> out_item.status <= ST_NO_COMMIT) else $error("bad status");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    !empty && out_item.status != ST_ENTRY |-> out_item.last)
    else $error("single result without last");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_item))
    else $error("waiting result changed");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> empty) else $error("results after reset");

endmodule

bind journal_transaction_tracker jtt_checker u_checker (
  .clk, .rst, .push, .full, .empty, .pop, .out_item
);
`default_nettype wire

/* bench/journal_transaction_tracker_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// journal_transaction_tracker_tb
// Self-checking bench for the journal transaction tracker.
// ----------------------------------------------------------------------------
// Each accepted input beat is run through a bench-side model of the journal
// bookkeeping (slot table, open operation count, pending commit flag). The
// model queues the result beats that the beat should cause. A checker takes
// every result beat and compares it field by field with the oldest queued
// result. Directed tests cover the edge cases first. Random transactions
// then run under several log layouts, with bursty input and a stalling
// result side.
// ----------------------------------------------------------------------------
module journal_transaction_tracker_tb;
  import jtt_pkg::*;

  localparam int CycleLimit = 400000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  in_item_t            in_item = '0;
  logic                empty;
  logic                pop = 1'b0;
  out_item_t           out_item;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = CFG_LOG_START;
  logic [31:0]         cfg_data = '0;

  // Bench copy of the tracker state and its two registers.
  logic [31:0] jt_table [LogSlots];
  int          jt_used;
  int          jt_open;
  bit          jt_pending;
  logic [31:0] jt_log_start;
  logic [31:0] jt_log_area;

  out_item_t   pending_results [$];
  int          errors = 0;
  int          beats_sent = 0;
  int          beats_checked = 0;
  int          commits_seen = 0;
  int          cycles = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b1;
  int          stall_pct = 0;

  journal_transaction_tracker u_top (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Watchdog: a hung handshake must not stall the run for ever.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time,
               pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // The result side stalls on its own pattern; a zero percentage gives
  // stretches in which every beat is taken at once.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic report(string field, logic [31:0] exp_v, logic [31:0] act_v);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_v, act_v);
    errors++;
  endtask

  // Every result beat is compared against the oldest queued prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got status %0d",
                 $time, out_item.status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (want.status != out_item.status)
          report("status", 32'(want.status), 32'(out_item.status));
        if (want.slot != out_item.slot)
          report("slot", 32'(want.slot), 32'(out_item.slot));
        if (want.home_block != out_item.home_block)
          report("home_block", want.home_block, out_item.home_block);
        if (want.log_block != out_item.log_block)
          report("log_block", want.log_block, out_item.log_block);
        if (want.last != out_item.last)
          report("last", 32'(want.last), 32'(out_item.last));
        if (want.open_count != out_item.open_count)
          report("open_count", 32'(want.open_count), 32'(out_item.open_count));
        if (want.status == ST_ENTRY && want.last) commits_seen++;
        beats_checked++;
      end
    end
  end

  // Works out the result beats of one accepted input beat and queues them.
  task automatic journal_predict(in_item_t it);
    out_item_t r;
    bit        found;
    int        n;
    r = '0;
    r.last = 1'b1;
    found = 1'b0;
    case (mode_t'(it.mode))
      MODE_BEGIN: begin
        if (jt_pending || jt_open >= int'(OpenMax) ||
            jt_used + (jt_open + 1) * MaxOpBlocks > LogSlots) begin
          r.status = ST_WAIT;
        end else begin
          jt_open++;
          r.status = ST_GRANTED;
        end
      end
      MODE_WRITE: begin
        // The full check comes before everything else, even outside a transaction.
        if (jt_used >= LogSlots || 64'(jt_used) + 64'd1 >= 64'(jt_log_area)) begin
          r.status = ST_FULL;
        end else if (jt_open == 0) begin
          r.status = ST_OUTSIDE;
        end else begin
          for (int i = 0; i < jt_used; i++) begin
            if (!found && jt_table[i] == it.block_number) begin
              found = 1'b1;
              r.status = ST_ABSORBED;
              r.slot = 5'(i);
            end
          end
          if (!found) begin
            jt_table[jt_used] = it.block_number;
            r.status = ST_APPENDED;
            r.slot = 5'(jt_used);
            jt_used++;
          end
          r.home_block = it.block_number;
          r.log_block = jt_log_start + 32'(r.slot) + 32'd1;
        end
      end
      MODE_END: begin
        if (jt_pending) begin
          r.status = ST_END_BUSY;
        end else if (jt_open == 0) begin
          r.status = ST_OUTSIDE;
        end else begin
          jt_open--;
          if (jt_open != 0 || jt_used == 0) begin
            r.status = ST_ENDED;
          end else begin
            // The last end lists the whole table, one beat per slot.
            jt_pending = 1'b1;
            n = jt_used;
            for (int i = 0; i < n; i++) begin
              r.status = ST_ENTRY;
              r.slot = 5'(i);
              r.home_block = jt_table[i];
              r.log_block = jt_log_start + 32'(i) + 32'd1;
              r.last = (i == n - 1);
              r.open_count = 3'(jt_open);
              if (i < n - 1) pending_results.push_back(r);
            end
            jt_used = 0;
          end
        end
      end
      default: begin
        if (!jt_pending) begin
          r.status = ST_NO_COMMIT;
        end else begin
          jt_pending = 1'b0;
          r.status = ST_FINISHED;
        end
      end
    endcase
    r.open_count = 3'(jt_open);
    pending_results.push_back(r);
  endtask

  // Sends one beat, waits for it to be taken, then maybe leaves a gap.
  task automatic send_beat(mode_t m, logic [31:0] blk);
    in_item_t it;
    it.mode = m;
    it.block_number = blk;
    in_item <= it;
    push <= 1'b1;
    do @(posedge clk); while (full);
    journal_predict(it);
    beats_sent++;
    if (burst_left > 0 || !gaps_on) begin
      burst_left--;
    end else begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  // Holds the input side off until every predicted result has come out.
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LOG_START) jt_log_start = value;
    else jt_log_area = value;
  endtask

  task automatic set_layout(logic [31:0] start, logic [31:0] area);
    write_reg(CFG_LOG_START, start);
    write_reg(CFG_LOG_AREA, area);
  endtask

  // A full transaction with duplicate and extreme block numbers, a second
  // end while the commit is pending, and both commit-done answers.
  task automatic test_basic_transaction();
    set_layout(32'hFFFF_FFFE, 32'd33);
    send_beat(MODE_BEGIN, 32'h0);
    send_beat(MODE_BEGIN, 32'hFFFF_FFFF);
    send_beat(MODE_WRITE, 32'h0000_0000);
    send_beat(MODE_WRITE, 32'hFFFF_FFFF);
    send_beat(MODE_WRITE, 32'h0000_0000);
    send_beat(MODE_WRITE, 32'hA5A5_5A5A);
    send_beat(MODE_END, 32'h0);
    send_beat(MODE_END, 32'h0);
    send_beat(MODE_BEGIN, 32'h0);
    send_beat(MODE_END, 32'h0);
    send_beat(MODE_DONE, 32'h0);
    send_beat(MODE_DONE, 32'h0);
  endtask

  // Misuse outside a transaction, a begin refused for space, and an end
  // with nothing logged, which needs no commit.
  task automatic test_misuse();
    send_beat(MODE_WRITE, 32'h1234_5678);
    send_beat(MODE_END, 32'h0);
    send_beat(MODE_BEGIN, 32'h0);
    send_beat(MODE_BEGIN, 32'h0);
    send_beat(MODE_BEGIN, 32'h0);
    send_beat(MODE_BEGIN, 32'h0);
    send_beat(MODE_END, 32'h0);
    send_beat(MODE_END, 32'h0);
    send_beat(MODE_END, 32'h0);
  endtask

  // The smallest log area has room for a single slot beside the header, so
  // the second distinct write answers full; the one entry is then committed.
  task automatic test_full_log();
    set_layout(32'h0, 32'd2);
    send_beat(MODE_WRITE, 32'h5);
    send_beat(MODE_BEGIN, 32'h0);
    send_beat(MODE_WRITE, 32'h5);
    send_beat(MODE_WRITE, 32'h6);
    send_beat(MODE_END, 32'h0);
    send_beat(MODE_DONE, 32'h0);
  endtask

  function automatic logic [31:0] pick_block(logic [31:0] base);
    if ($urandom_range(0, 9) < 7) return base + 32'($urandom_range(0, 15));
    return $urandom;
  endfunction

  // Well-formed transactions with random content, mixed with noise beats.
  task automatic run_random(int beats);
    int          start_beats;
    int          ops;
    logic [31:0] base;
    start_beats = beats_sent;
    while (beats_sent - start_beats < beats) begin
      if ($urandom_range(0, 4) == 0) begin
        send_beat(mode_t'($urandom_range(0, 3)), $urandom);
      end else begin
        base = $urandom;
        ops = $urandom_range(1, 3);
        for (int i = 0; i < ops; i++) send_beat(MODE_BEGIN, $urandom);
        repeat ($urandom_range(0, 14)) begin
          if ($urandom_range(0, 5) == 0 && ops > 1) begin
            send_beat(MODE_END, $urandom);
            ops--;
          end
          send_beat(MODE_WRITE, pick_block(base));
        end
        for (int i = 0; i < ops; i++) send_beat(MODE_END, $urandom);
        if ($urandom_range(0, 3) == 0) send_beat(MODE_END, $urandom);
        send_beat(MODE_DONE, $urandom);
      end
    end
  endtask

  task automatic test_random_layouts();
    gaps_on = 1'b0;
    stall_pct = 0;
    set_layout(32'h0, 32'd33);
    run_random(70);
    gaps_on = 1'b1;
    stall_pct = 40;
    set_layout(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random(70);
    stall_pct = 75;
    set_layout($urandom, 32'd8);
    run_random(70);
    stall_pct = 20;
    set_layout(32'h7FFF_FFF0, 32'd20);
    run_random(70);
    stall_pct = 50;
    set_layout($urandom, 32'($urandom_range(2, 40)));
    run_random(70);
  endtask

  initial begin
    jt_used = 0;
    jt_open = 0;
    jt_pending = 1'b0;
    jt_log_start = 32'h0;
    jt_log_area = 32'd33;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    stall_pct = 30;
    test_basic_transaction();
    test_misuse();
    test_full_log();
    test_random_layouts();
    wait_drained();
    repeat (40) @(posedge clk);
    $display("Sent %0d input beats, checked %0d result beats, %0d commit listings.",
             beats_sent, beats_checked, commits_seen);
    $display("Covered misuse codes, full log, waits and five log layouts.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/jtt_pkg.sv
hw/rtl/jtt_front.sv
hw/rtl/jtt_back.sv
hw/rtl/journal_transaction_tracker.sv
hw/rtl/jtt_checker.sv
bench/journal_transaction_tracker_tb.sv
